// File: design/lfs_pkg.sv
// Shared types, constants and helpers for the friction step unit.
package lfs_pkg;

	localparam int CFG_W    = 31;
	localparam int DATA_W   = 32;
	localparam int MUL_A_W  = 64;
	localparam int MUL_B_W  = 32;
	localparam int MUL_P_W  = 96;
	localparam int DIV_N_W  = 96;
	localparam int DIV_D_W  = 47;
	localparam int QUO_W    = 41;
	localparam int EXP_W    = 17;
	localparam int U_W      = 19;
	localparam int ADDR_W   = 5;
	localparam int SUM_W    = 49;

	localparam logic [2:0] REG_S0 = 3'd0;
	localparam logic [2:0] REG_S1 = 3'd1;
	localparam logic [2:0] REG_S2 = 3'd2;
	localparam logic [2:0] REG_VS = 3'd3;
	localparam logic [2:0] REG_FC = 3'd4;
	localparam logic [2:0] REG_FS = 3'd5;
	localparam logic [2:0] REG_DT = 3'd6;

	localparam logic [CFG_W-1:0] VS_RESET = 31'd65536;
	localparam logic [CFG_W-1:0] DT_RESET = 31'd66;
	localparam logic [QUO_W-1:0] QCAP     = 41'h100_0000_0000;
	localparam logic [QUO_W-1:0] R_LIMIT  = 41'd196608;

	typedef enum logic [3:0] {
		ST_IDLE, ST_TRQ0, ST_TRQ1, ST_TRQ2, ST_RDIV, ST_USQ, ST_ELOOK,
		ST_GMUL, ST_MAV, ST_MZ, ST_QDIV, ST_ZD, ST_DTM, ST_EMIT
	} lfs_state_t;

	function automatic logic [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
		logic [DATA_W-1:0] r;
		if (x > $signed(49'sh0_7FFF_FFFF))
			r = 32'h7FFF_FFFF;
		else if (x < $signed(-49'sh0_8000_0000))
			r = 32'h8000_0000;
		else
			r = x[DATA_W-1:0];
		return r;
	endfunction

endpackage

// File: design/lfs_mul.sv
// Bit-serial signed-by-unsigned multiplier, one multiplier bit per cycle.
`default_nettype none
module lfs_mul (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic signed [lfs_pkg::MUL_A_W-1:0]  a,
	input  wire logic        [lfs_pkg::MUL_B_W-1:0]  b,
	output logic                                     done,
	output logic signed      [lfs_pkg::MUL_P_W-1:0]  p
);
	import lfs_pkg::*;

	logic signed [MUL_A_W:0]   hi_q;
	logic        [MUL_B_W-1:0] lo_q;
	logic signed [MUL_A_W-1:0] a_q;
	logic        [4:0]         cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic signed [MUL_A_W:0]   sum;

	assign sum  = hi_q + (lo_q[0] ? {a_q[MUL_A_W-1], a_q} : '0);
	assign done = done_q;
	assign p    = {hi_q[MUL_A_W-1:0], lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hi_q <= '0;
			lo_q <= b;
			a_q  <= a;
		end else if (busy_q) begin
			hi_q <= {sum[MUL_A_W], sum[MUL_A_W:1]};
			lo_q <= {sum[0], lo_q[MUL_B_W-1:1]};
		end
	end
endmodule
`default_nettype wire

// File: design/lfs_div.sv
// Radix-2 restoring divider with a quotient that saturates at 2^40.
`default_nettype none
module lfs_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [lfs_pkg::DIV_N_W-1:0]   n,
	input  wire logic [lfs_pkg::DIV_D_W-1:0]   d,
	output logic                               done,
	output logic [lfs_pkg::QUO_W-1:0]          q
);
	import lfs_pkg::*;

	logic [DIV_N_W-1:0] n_q;
	logic [DIV_D_W-1:0] d_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [QUO_W-1:0]   q_q;
	logic               ovf_q;
	logic [6:0]         cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DIV_D_W:0]   trial;
	logic [DIV_D_W:0]   shifted;

	assign shifted = {rem_q, n_q[DIV_N_W-1]};
	assign trial   = shifted - {1'b0, d_q};
	assign done    = done_q;
	assign q       = (ovf_q || q_q[QUO_W-1]) ? QCAP : q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n;
			d_q   <= d;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			n_q   <= {n_q[DIV_N_W-2:0], 1'b0};
			ovf_q <= ovf_q | q_q[QUO_W-1];
			if (!trial[DIV_D_W]) begin
				rem_q <= trial[DIV_D_W-1:0];
				q_q   <= {q_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DIV_D_W-1:0];
				q_q   <= {q_q[QUO_W-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// File: design/lfs_exp_rom.sv
// Constant table of exp(-x) over 0 <= x < 8, indexed from the squared ratio.
`default_nettype none
module lfs_exp_rom #(
	parameter int DEPTH = 256
) (
	input  wire logic [lfs_pkg::U_W-1:0]   u,
	output logic      [lfs_pkg::EXP_W-1:0] e
);
	import lfs_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int DW = $clog2(DEPTH + 1);

	typedef logic [EXP_W-1:0] tab_t [DEPTH];

	function automatic tab_t build_tab();
		logic [63:0] a;
		logic [63:0] term;
		logic [63:0] qv;
		logic [63:0] c;
		tab_t        t;
		a    = (64'd8 << 32) / 64'(DEPTH);
		term = 64'd1 << 32;
		qv   = term;
		c    = term;
		for (int k = 1; k <= 24; k++) begin
			term = ((term * a) >> 32) / 64'(k);
			if (k % 2 == 1)
				qv = qv - term;
			else
				qv = qv + term;
		end
		for (int i = 0; i < DEPTH; i++) begin
			t[i] = EXP_W'((c + 64'd32768) >> 16);
			c    = (c * qv + (64'd1 << 31)) >> 32;
		end
		return t;
	endfunction

	localparam tab_t TAB = build_tab();

	logic [U_W+DW-1:0] scaled;
	logic [IW-1:0]     idx;

	assign scaled = (U_W+DW)'(u) * (U_W+DW)'(DEPTH);
	assign idx    = scaled[U_W +: IW];
	assign e      = TAB[idx];
endmodule
`default_nettype wire

// File: design/lugre_friction_step_unit.sv
// LuGre friction step unit: top level with register file, sequencer and result register.
// A restart beat only loads the start deflection and rate and arms the unit. A step beat
// runs through the sequencer from acceptance to the result register. Eight products go
// through the shared bit-serial multiplier, each with launch and hand-off. Two quotients
// go through the shared radix-2 divider: the Stribeck ratio and the bristle term. The
// table lookup, the rate update and the result load have a state each. When the velocity
// is at or beyond three Stribeck velocities, the squaring and the lookup are skipped.
// When g is zero, the bristle quotient is skipped. A step before any restart goes
// straight to the result load and returns not_started with torque 0. The input side
// takes a new beat as soon as the result sits in the output register.
`default_nettype none
module lugre_friction_step_unit #(
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// [31:0] velocity, [63:32] start_deflection, [95:64] start_rate
	input  wire logic [95:0]                   s_axis_tdata,
	// [0] kind
	input  wire logic                          s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// [31:0] torque
	output logic [31:0]                        m_axis_tdata,
	// [0] not_started
	output logic                               m_axis_tuser,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [lfs_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import lfs_pkg::*;

	logic [CFG_W-1:0] s0_q, s1_q, s2_q, vs_q, fc_q, fs_q, dt_q;
	logic [2:0]       reg_idx;
	logic             cfg_wr;

	lfs_state_t state_q, state_nx;
	logic       launched_q;
	logic       mul_start, div_start, mul_done, div_done, unit_done;
	logic       is_mul, is_div;

	logic signed [MUL_A_W-1:0] mul_a;
	logic        [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	logic        [DIV_N_W-1:0] div_n;
	logic        [DIV_D_W-1:0] div_d;
	logic        [QUO_W-1:0]   div_q;

	logic signed [DATA_W-1:0] z_q, zr_q, v_q, zd_new_q;
	logic                     started_q, nst_q;
	logic        [DATA_W-1:0] av_q, az;
	logic signed [SUM_W-1:0]  tq_q;
	logic        [QUO_W-1:0]  r_q, q_q;
	logic        [19:0]       u_q;
	logic        [EXP_W-1:0]  e_q, rom_e;
	logic        [CFG_W-1:0]  g_q, vs_eff;
	logic        [62:0]       m_q;
	logic        [94:0]       prod_q;
	logic signed [SUM_W-1:0]  p_term;
	logic        [SUM_W-1:0]  g_sum;
	logic        [QUO_W-1:0]  q_eff;
	logic signed [QUO_W:0]    sq;
	logic signed [QUO_W+1:0]  zd_full;
	logic signed [SUM_W-1:0]  zn_full;
	logic                     in_acc, out_load;
	logic        [DATA_W-1:0] tq_sat;

	logic                     m_valid_q;
	logic        [DATA_W-1:0] m_data_q;
	logic                     m_user_q;

	// register file
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_q <= '0; s1_q <= '0; s2_q <= '0; vs_q <= VS_RESET;
			fc_q <= '0; fs_q <= '0; dt_q <= DT_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_S0:  s0_q <= pwdata[CFG_W-1:0];
				REG_S1:  s1_q <= pwdata[CFG_W-1:0];
				REG_S2:  s2_q <= pwdata[CFG_W-1:0];
				REG_VS:  vs_q <= pwdata[CFG_W-1:0];
				REG_FC:  fc_q <= pwdata[CFG_W-1:0];
				REG_FS:  fs_q <= pwdata[CFG_W-1:0];
				REG_DT:  dt_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_S0:  prdata = {1'b0, s0_q};
			REG_S1:  prdata = {1'b0, s1_q};
			REG_S2:  prdata = {1'b0, s2_q};
			REG_VS:  prdata = {1'b0, vs_q};
			REG_FC:  prdata = {1'b0, fc_q};
			REG_FS:  prdata = {1'b0, fs_q};
			REG_DT:  prdata = {1'b0, dt_q};
			default: prdata = '0;
		endcase
	end

	// arithmetic units
	lfs_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a), .b(mul_b), .done(mul_done), .p(mul_p)
	);

	lfs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.n(div_n), .d(div_d), .done(div_done), .q(div_q)
	);

	lfs_exp_rom #(.DEPTH(EXP_TABLE_DEPTH)) u_rom (
		.u(u_q[U_W-1:0]), .e(rom_e)
	);

	assign in_acc    = s_axis_tvalid & s_axis_tready;
	assign out_load  = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);
	assign unit_done = mul_done | div_done;
	assign vs_eff    = (vs_q == '0) ? CFG_W'(1) : vs_q;
	assign az        = z_q[DATA_W-1] ? DATA_W'(-z_q) : DATA_W'(z_q);
	assign p_term    = {mul_p[63], mul_p[63:16]};
	assign g_sum     = SUM_W'(fc_q) + SUM_W'(p_term);
	assign q_eff     = (g_q == '0) ? ((prod_q != '0) ? QCAP : '0) : q_q;
	assign sq        = z_q[DATA_W-1] ? -$signed({1'b0, q_eff}) : $signed({1'b0, q_eff});
	assign zd_full   = (QUO_W+2)'(v_q) - (QUO_W+2)'(sq);
	assign zn_full   = SUM_W'(z_q) + p_term;
	assign tq_sat    = sat32(tq_q);

	// sequencer
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_acc && !s_axis_tuser) state_nx = started_q ? ST_TRQ0 : ST_EMIT;
			ST_TRQ0:  if (unit_done) state_nx = ST_TRQ1;
			ST_TRQ1:  if (unit_done) state_nx = ST_TRQ2;
			ST_TRQ2:  if (unit_done) state_nx = ST_RDIV;
			ST_RDIV:  if (unit_done) state_nx = (div_q < R_LIMIT) ? ST_USQ : ST_GMUL;
			ST_USQ:   if (unit_done) state_nx = ST_ELOOK;
			ST_ELOOK: state_nx = ST_GMUL;
			ST_GMUL:  if (unit_done) state_nx = ST_MAV;
			ST_MAV:   if (unit_done) state_nx = ST_MZ;
			ST_MZ:    if (unit_done) state_nx = (g_q == '0) ? ST_ZD : ST_QDIV;
			ST_QDIV:  if (unit_done) state_nx = ST_ZD;
			ST_ZD:    state_nx = ST_DTM;
			ST_DTM:   if (unit_done) state_nx = ST_EMIT;
			ST_EMIT:  if (out_load) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		is_mul = 1'b0;
		is_div = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		div_n  = '0;
		div_d  = '0;
		unique case (state_q)
			ST_TRQ0: begin
				is_mul = 1'b1; mul_a = MUL_A_W'(z_q);  mul_b = MUL_B_W'(s0_q);
			end
			ST_TRQ1: begin
				is_mul = 1'b1; mul_a = MUL_A_W'(zr_q); mul_b = MUL_B_W'(s1_q);
			end
			ST_TRQ2: begin
				is_mul = 1'b1; mul_a = MUL_A_W'(v_q);  mul_b = MUL_B_W'(s2_q);
			end
			ST_RDIV: begin
				is_div = 1'b1;
				div_n  = {48'd0, av_q, 16'd0};
				div_d  = DIV_D_W'(vs_eff);
			end
			ST_USQ: begin
				is_mul = 1'b1;
				mul_a  = MUL_A_W'(r_q[17:0]);
				mul_b  = MUL_B_W'(r_q[17:0]);
			end
			ST_GMUL: begin
				is_mul = 1'b1;
				mul_a  = MUL_A_W'($signed({1'b0, fs_q}) - $signed({1'b0, fc_q}));
				mul_b  = MUL_B_W'(e_q);
			end
			ST_MAV: begin
				is_mul = 1'b1; mul_a = MUL_A_W'(av_q); mul_b = MUL_B_W'(s0_q);
			end
			ST_MZ: begin
				is_mul = 1'b1; mul_a = {1'b0, m_q}; mul_b = az;
			end
			ST_QDIV: begin
				is_div = 1'b1;
				div_n  = {1'b0, prod_q};
				div_d  = {g_q, 16'd0};
			end
			ST_DTM: begin
				is_mul = 1'b1; mul_a = MUL_A_W'(zd_new_q); mul_b = MUL_B_W'(dt_q);
			end
			default: ;
		endcase
		mul_start     = is_mul && !launched_q;
		div_start     = is_div && !launched_q;
		s_axis_tready = (state_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			launched_q <= 1'b0;
			started_q  <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (unit_done)
				launched_q <= 1'b0;
			else if (mul_start || div_start)
				launched_q <= 1'b1;
			if (in_acc && s_axis_tuser)
				started_q <= 1'b1;
			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z_q  <= '0;
			zr_q <= '0;
		end else if (in_acc && s_axis_tuser) begin
			z_q  <= $signed(s_axis_tdata[63:32]);
			zr_q <= $signed(s_axis_tdata[95:64]);
		end else if (state_q == ST_DTM && unit_done) begin
			z_q  <= $signed(sat32(zn_full));
			zr_q <= zd_new_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && !s_axis_tuser) begin
			nst_q <= !started_q;
			v_q   <= $signed(s_axis_tdata[31:0]);
			av_q  <= s_axis_tdata[31] ? -s_axis_tdata[31:0] : s_axis_tdata[31:0];
		end
		if (unit_done) begin
			unique case (state_q)
				ST_TRQ0: tq_q <= p_term;
				ST_TRQ1, ST_TRQ2: tq_q <= tq_q + p_term;
				ST_RDIV: begin
					r_q <= div_q;
					e_q <= '0;
				end
				ST_USQ:  u_q    <= mul_p[35:16];
				ST_GMUL: g_q    <= g_sum[CFG_W-1:0];
				ST_MAV:  m_q    <= mul_p[62:0];
				ST_MZ:   prod_q <= mul_p[94:0];
				ST_QDIV: q_q    <= div_q;
				default: ;
			endcase
		end
		if (state_q == ST_ELOOK)
			e_q <= u_q[19] ? '0 : rom_e;
		if (state_q == ST_ZD)
			zd_new_q <= $signed(sat32(SUM_W'(zd_full)));
		if (out_load) begin
			m_data_q <= nst_q ? '0 : tq_sat;
			m_user_q <= nst_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
endmodule
`default_nettype wire

// File: design/lfs_checker.sv
// Port-level checks for the friction step unit, bound to the top level.
`default_nettype none
module lfs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic        m_axis_tuser,
	input wire logic        pready
);
	a_nst_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
		else $error("not_started beat with nonzero torque");

	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !s_axis_tready)
		else $error("step beat did not occupy the unit");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result beat changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");
endmodule

bind lugre_friction_step_unit lfs_checker u_lfs_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.s_axis_tuser(s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
	.pready(pready)
);
`default_nettype wire

// File: tb/lugre_friction_step_unit_tb.sv
// Self-checking testbench for the LuGre friction step unit: random stream and register traffic.
`default_nettype none
module lugre_friction_step_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lfs_pkg::*;

	localparam int TABLE_DEPTH = 256;
	localparam int DOG_LIMIT   = 20000;
	localparam int SETTLE      = 700;
	localparam bit KIND_STEP    = 1'b0;
	localparam bit KIND_RESTART = 1'b1;

	typedef struct {
		logic [31:0] torque;
		bit          not_started;
	} friction_result_t;

	class friction_scoreboard;
		logic [30:0] stiffness, damping, viscous, stribeck, coulomb, stiction, dt;
		longint deflection, rate;
		bit armed;
		logic [31:0] exp_lut [TABLE_DEPTH];
		friction_result_t pending [$];
		int errors;

		function new();
			logic [63:0] a, term, q, c;
			a = (64'd8 << 32) / TABLE_DEPTH;
			term = 64'd1 << 32;
			q = term;
			c = term;
			for (int k = 1; k <= 24; k++) begin
				term = ((term * a) >> 32) / k;
				if (k % 2) q = q - term; else q = q + term;
			end
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				exp_lut[i] = 32'((c + 64'd32768) >> 16);
				c = (c * q + (64'd1 << 31)) >> 32;
			end
			stiffness = 0; damping = 0; viscous = 0; stribeck = VS_RESET;
			coulomb = 0; stiction = 0; dt = DT_RESET;
			deflection = 0; rate = 0; armed = 0; errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] value);
			case (idx)
				REG_S0: stiffness = value[30:0];
				REG_S1: damping = value[30:0];
				REG_S2: viscous = value[30:0];
				REG_VS: stribeck = value[30:0];
				REG_FC: coulomb = value[30:0];
				REG_FS: stiction = value[30:0];
				REG_DT: dt = value[30:0];
				default: ;
			endcase
		endfunction

		function longint clamp32(longint x);
			if (x > 64'sd2147483647) return 64'sd2147483647;
			if (x < -64'sd2147483648) return -64'sd2147483648;
			return x;
		endfunction

		function void note_beat(bit kind, logic [31:0] vel, logic [31:0] z0, logic [31:0] zr0);
			friction_result_t res;
			longint v, trq, g, zd, sq;
			longint unsigned av, az, vsv, r, u, e, m;
			logic [127:0] prod, quo;
			if (kind == KIND_RESTART) begin
				deflection = longint'($signed(z0));
				rate = longint'($signed(zr0));
				armed = 1;
				return;
			end
			if (!armed) begin
				res.torque = 0;
				res.not_started = 1;
				pending.push_back(res);
				return;
			end
			v = longint'($signed(vel));
			trq = ((longint'(stiffness) * deflection) >>> 16)
				+ ((longint'(damping) * rate) >>> 16)
				+ ((longint'(viscous) * v) >>> 16);
			res.torque = 32'(clamp32(trq));
			res.not_started = 0;
			pending.push_back(res);

			av = v < 0 ? -v : v;
			vsv = stribeck != 0 ? longint'(stribeck) : 1;
			r = (av << 16) / vsv;
			e = 0;
			if (r < (64'd3 << 16)) begin
				u = (r * r) >> 16;
				if (u < (64'd8 << 16))
					e = exp_lut[(u * TABLE_DEPTH) / (64'd8 << 16)];
			end
			g = longint'(coulomb)
				+ (((longint'(stiction) - longint'(coulomb)) * longint'(e)) >>> 16);
			m = longint'(stiffness) * av;
			az = deflection < 0 ? -deflection : deflection;
			prod = 128'(m) * 128'(az);
			if (g <= 0)
				quo = prod != 0 ? 128'(QCAP) : 128'd0;
			else begin
				quo = prod / (128'(g) << 16);
				if (quo > 128'(QCAP)) quo = 128'(QCAP);
			end
			sq = deflection < 0 ? -longint'(quo) : longint'(quo);
			zd = clamp32(v - sq);
			deflection = clamp32(deflection + ((longint'(dt) * zd) >>> 16));
			rate = zd;
		endfunction

		task report(string what);
			errors++;
			$display("mismatch at %0t: %s", $time, what);
		endtask

		task check_beat(logic [31:0] torque, logic not_started);
			friction_result_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected beat torque %h", torque));
				return;
			end
			want = pending.pop_front();
			if (torque !== want.torque)
				report($sformatf("torque %h, want %h", torque, want.torque));
			if (not_started !== want.not_started)
				report($sformatf("not_started %b, want %b", not_started, want.not_started));
		endtask
	endclass

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
	logic [95:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready, m_axis_tuser;
	logic [31:0] m_axis_tdata;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;

	friction_scoreboard sb;
	bit calm;
	int stall_left;
	int dog;

	lugre_friction_step_unit #(.EXP_TABLE_DEPTH(TABLE_DEPTH)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			sb.note_beat(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
				s_axis_tdata[95:64]);
		if (m_axis_tvalid && m_axis_tready)
			sb.check_beat(m_axis_tdata, m_axis_tuser);
	end

	always @(posedge clk) begin
		if (calm)
			m_axis_tready <= 1;
		else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 0;
		end else if ($urandom_range(5) == 0) begin
			stall_left <= $urandom_range(6);
			m_axis_tready <= 0;
		end else
			m_axis_tready <= 1;
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			dog <= 0;
		else
			dog <= dog + 1;
		if (dog >= DOG_LIMIT) begin
			$display("lugre_friction_step_unit_tb NOT OK");
			$finish;
		end
	end

	task reg_write(logic [2:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		sb.write_reg(idx, value);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task load_all(logic [31:0] s0, logic [31:0] s1, logic [31:0] s2, logic [31:0] vs,
			logic [31:0] fc, logic [31:0] fs, logic [31:0] dt);
		reg_write(REG_S0, s0);
		reg_write(REG_S1, s1);
		reg_write(REG_S2, s2);
		reg_write(REG_VS, vs);
		reg_write(REG_FC, fc);
		reg_write(REG_FS, fs);
		reg_write(REG_DT, dt);
	endtask

	task drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task send_beat(bit kind, logic [31:0] vel, logic [31:0] z0, logic [31:0] zr0);
		int gap;
		if (!calm && $urandom_range(3) == 0) begin
			gap = $urandom_range(1, 7);
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {zr0, z0, vel};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task release_bus();
		s_axis_tvalid <= 0;
		@(posedge clk);
	endtask

	function logic [31:0] pick_vel(logic [30:0] vs);
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
			default: return 32'(int'($urandom_range(0, 4 * int'(vs[29:0]) + 2))
				- 2 * int'(vs[29:0]) - 1);
		endcase
	endfunction

	task random_run(int count);
		logic [31:0] z0, zr0;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(11) == 0) begin
				z0 = $urandom_range(1) ? $urandom : 32'($signed($urandom_range(0, 131072)) - 65536);
				zr0 = $urandom_range(1) ? $urandom : 32'($signed($urandom_range(0, 131072)) - 65536);
				send_beat(KIND_RESTART, $urandom, z0, zr0);
			end else
				send_beat(KIND_STEP, pick_vel(sb.stribeck), $urandom, $urandom);
		end
		release_bus();
	endtask

	initial begin
		sb = new();
		calm = 0;
		stall_left = 0;
		dog = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tuser = 0;
		s_axis_tdata = 0;
		m_axis_tready = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_beat(KIND_STEP, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0);
		send_beat(KIND_STEP, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
		send_beat(KIND_RESTART, 32'h1234_5678, 32'h0001_0000, 32'hFFFF_8000);
		send_beat(KIND_STEP, 32'h0001_0000, 32'h5555_5555, 32'hAAAA_AAAA);
		release_bus();
		drain();

		load_all(32'h0010_0000, 32'h0000_8000, 32'h0000_4000, 32'h0000_8000,
			32'h0001_0000, 32'h0001_8000, 32'd66);
		reg_write(3'd7, 32'hFFFF_FFFF);
		send_beat(KIND_RESTART, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
		send_beat(KIND_STEP, 32'h0, 32'h0, 32'h0);
		send_beat(KIND_STEP, 32'h7FFF_FFFF, 32'h0, 32'h0);
		send_beat(KIND_STEP, 32'h8000_0000, 32'h0, 32'h0);
		send_beat(KIND_STEP, 32'hFFFF_FFFF, 32'h0, 32'h0);
		send_beat(KIND_STEP, 32'h0001_7FFF, 32'h0, 32'h0);
		send_beat(KIND_RESTART, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_beat(KIND_STEP, 32'h0000_4000, 32'h0, 32'h0);
		send_beat(KIND_STEP, 32'hFFFF_C000, 32'h0, 32'h0);
		release_bus();
		drain();

		load_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_beat(KIND_RESTART, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_beat(KIND_STEP, 32'h7FFF_FFFF, 32'h0, 32'h0);
		send_beat(KIND_STEP, 32'h8000_0000, 32'h0, 32'h0);
		random_run(40);
		drain();

		load_all(32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
		send_beat(KIND_RESTART, 32'h0, 32'h0001_0000, 32'h0);
		send_beat(KIND_STEP, 32'h0000_0001, 32'h0, 32'h0);
		send_beat(KIND_STEP, 32'h0, 32'h0, 32'h0);
		random_run(30);
		drain();

		for (int p = 0; p < 4; p++) begin
			load_all($urandom_range(0, 32'h0100_0000), $urandom_range(0, 32'h0010_0000),
				$urandom_range(0, 32'h0010_0000), $urandom_range(1, 32'h0004_0000),
				$urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0004_0000),
				$urandom_range(0, 32'h0000_1000));
			send_beat(KIND_RESTART, $urandom, 32'($signed($urandom_range(0, 131072)) - 65536),
				$urandom);
			random_run(60);
			drain();
		end

		load_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		send_beat(KIND_RESTART, $urandom, $urandom, $urandom);
		random_run(40);
		drain();

		calm = 1;
		load_all(32'h0008_0000, 32'h0000_4000, 32'h0000_2000, 32'h0001_0000,
			32'h0000_C000, 32'h0001_4000, 32'd131);
		send_beat(KIND_RESTART, 32'h0, 32'h0, 32'h0);
		random_run(60);
		drain();

		if (sb.errors == 0)
			$display("lugre_friction_step_unit_tb OK");
		else
			$display("lugre_friction_step_unit_tb NOT OK");
		$finish;
	end

endmodule
